// File: rtl/zbfs_pkg.sv
// Shared types and constants of the z-buffered frame store.
package zbfs_pkg;

   localparam int CFG_W       = 9;
   localparam int COORD_W     = 12;
   localparam int CHAN_W      = 16;
   localparam int COLOR_W     = 12;
   localparam int ALPHA_W     = 16;
   localparam int DEPTH_W     = 32;
   localparam int LIN_W       = 20;
   localparam int PROD_W      = 18;
   localparam int REQ_TDATA_W = 120;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 88;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [COLOR_W-1:0] COLOR_MAX   = 12'd4095;
   localparam logic [COLOR_W-1:0] COLOR_WHITE = 12'h0fff;
   localparam logic [ALPHA_W-1:0] CLEAR_ALPHA = 16'd1;
   localparam logic [DEPTH_W-1:0] CLEAR_DEPTH = 32'd0;
   localparam logic [CFG_W-1:0]   FRAME_RESET = 9'd256;

   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      REQ_CLEAR  = 2'd0,
      REQ_WRITE  = 2'd1,
      REQ_READ   = 2'd2,
      REQ_IGNORE = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic capture;
      logic calc;
      logic mem_rd;
      logic clear_wr;
      logic clear_done;
      logic pix_wr;
      logic rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      req_kind_type kind;
      logic         hit;
      logic         depth_pass;
      logic         clear_more;
      logic         rsp_free;
   } dp_status_type;

endpackage

// File: rtl/zbfs_csr.sv
// Configuration register bank holding the frame width and height.
module zbfs_csr import zbfs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [CFG_W-1:0]      frame_width,
   output logic [CFG_W-1:0]      frame_height
);

   logic [CFG_W-1:0] frame_width_ff, frame_width_in;
   logic [CFG_W-1:0] frame_height_ff, frame_height_in;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      csr_prdata      = '0;
      unique case (csr_paddr[2])
         REG_FRAME_WIDTH: begin
            csr_prdata = CSR_DATA_W'(frame_width_ff);
            if (wr_en) begin
               frame_width_in = csr_pwdata[CFG_W-1:0];
            end
         end
         REG_FRAME_HEIGHT: begin
            csr_prdata = CSR_DATA_W'(frame_height_ff);
            if (wr_en) begin
               frame_height_in = csr_pwdata[CFG_W-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_RESET;
         frame_height_ff <= FRAME_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   assign frame_width  = frame_width_ff;
   assign frame_height = frame_height_ff;

endmodule

// File: rtl/zbfs_ctrl.sv
// Controller state machine sequencing clear, write and read items.
module zbfs_ctrl import zbfs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CALC  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_CHECK = 5'b01000,
      ST_CLEAR = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            unique case (status.kind)
               REQ_CLEAR:  state_in = ST_CLEAR;
               REQ_WRITE:  state_in = ST_READ;
               REQ_READ:   state_in = ST_READ;
               REQ_IGNORE: state_in = ST_IDLE;
               default:    state_in = ST_IDLE;
            endcase
         end
         ST_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.kind == REQ_READ) begin
               if (status.rsp_free) begin
                  cmd.rsp_load = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.pix_wr = status.hit && status.depth_pass;
               state_in   = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            if (status.clear_more) begin
               cmd.clear_wr = 1'b1;
            end else begin
               cmd.clear_done = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_wr_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clear_wr && cmd.pix_wr))
      else $error("clear and pixel write issued together");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> status.rsp_free)
      else $error("result loaded while output register busy");

   a_accept_calc: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_CALC))
      else $error("accepted item did not advance to address calculation");

endmodule

// File: rtl/zbfs_dp.sv
// Datapath: request capture, address calculation, pixel memories and output register.
module zbfs_dp import zbfs_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_cmd_type           cmd,
   output dp_status_type          status,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   input  logic [CFG_W-1:0]       frame_width,
   input  logic [CFG_W-1:0]       frame_height,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tuser
);

   localparam int PIX_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW        = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
   localparam int COLOR3_W  = 3 * COLOR_W;
   localparam int AD_W      = ALPHA_W + DEPTH_W;

   function automatic logic [COLOR_W-1:0] clamp_color(input logic signed [CHAN_W-1:0] v);
      logic [COLOR_W-1:0] res;
      if (v < 0) begin
         res = '0;
      end else if (v > $signed({{(CHAN_W-COLOR_W){1'b0}}, COLOR_MAX})) begin
         res = COLOR_MAX;
      end else begin
         res = v[COLOR_W-1:0];
      end
      return res;
   endfunction

   // captured request
   req_kind_type              kind_ff, kind_in;
   logic signed [COORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [CHAN_W-1:0]         red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic [ALPHA_W-1:0]        alpha_ff, alpha_in;
   logic [DEPTH_W-1:0]        depth_ff, depth_in;

   // address and clear walk
   logic [CFG_W-1:0]  eff_w, eff_h;
   logic [LIN_W-1:0]  lin;
   logic              hit_ff, hit_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [PROD_W-1:0] total_ff, total_in;
   logic [PROD_W-1:0] cursor_ff, cursor_in;

   // pixel memories
   logic [COLOR3_W-1:0] pixel_color_ff [PIX_DEPTH];
   logic [AD_W-1:0]     pixel_alpha_depth_ff [PIX_DEPTH];
   logic [COLOR3_W-1:0] rd_color_ff;
   logic [AD_W-1:0]     rd_ad_ff;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [COLOR3_W-1:0] wr_color;
   logic [AD_W-1:0]     wr_ad;
   logic [DEPTH_W-1:0]  old_depth;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0]  rsp_red_ff, rsp_red_in, rsp_green_ff, rsp_green_in;
   logic [COLOR_W-1:0]  rsp_blue_ff, rsp_blue_in;
   logic [ALPHA_W-1:0]  rsp_alpha_ff, rsp_alpha_in;
   logic [DEPTH_W-1:0]  rsp_depth_ff, rsp_depth_in;
   logic                rsp_hit_ff, rsp_hit_in;

   always_comb begin
      kind_in  = kind_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      red_in   = red_ff;
      green_in = green_ff;
      blue_in  = blue_ff;
      alpha_in = alpha_ff;
      depth_in = depth_ff;
      if (cmd.capture) begin
         kind_in  = req_kind_type'(req_tuser);
         x_in     = req_tdata[11:0];
         y_in     = req_tdata[23:12];
         red_in   = req_tdata[39:24];
         green_in = req_tdata[55:40];
         blue_in  = req_tdata[71:56];
         alpha_in = req_tdata[87:72];
         depth_in = req_tdata[119:88];
      end
   end

   always_comb begin
      eff_w = (int'(frame_width) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : frame_width;
      eff_h = (int'(frame_height) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : frame_height;
      lin   = (LIN_W'(y_ff[COORD_W-2:0]) * LIN_W'(eff_w)) + LIN_W'(x_ff[COORD_W-2:0]);
      hit_in  = hit_ff;
      addr_in = addr_ff;
      if (cmd.calc) begin
         hit_in = !x_ff[COORD_W-1] && !y_ff[COORD_W-1]
                  && ({1'b0, x_ff[COORD_W-2:0]} < {3'b000, eff_w})
                  && ({1'b0, y_ff[COORD_W-2:0]} < {3'b000, eff_h});
         addr_in = AW'(lin);
      end
      total_in  = PROD_W'(eff_w) * PROD_W'(eff_h);
      cursor_in = cursor_ff;
      if (cmd.clear_done) begin
         cursor_in = '0;
      end else if (cmd.clear_wr) begin
         cursor_in = cursor_ff + PROD_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
      end else begin
         cursor_ff <= cursor_in;
      end
      kind_ff  <= kind_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
      alpha_ff <= alpha_in;
      depth_ff <= depth_in;
      hit_ff   <= hit_in;
      addr_ff  <= addr_in;
      total_ff <= total_in;
   end

   // write port: clear walk or depth-tested pixel write
   always_comb begin
      wr_en = cmd.clear_wr || cmd.pix_wr;
      if (cmd.clear_wr) begin
         wr_addr  = AW'(cursor_ff);
         wr_color = {COLOR_WHITE, COLOR_WHITE, COLOR_WHITE};
         wr_ad    = {CLEAR_ALPHA, CLEAR_DEPTH};
      end else begin
         wr_addr  = addr_ff;
         wr_color = {clamp_color(blue_ff), clamp_color(green_ff), clamp_color(red_ff)};
         wr_ad    = {alpha_ff, depth_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pixel_color_ff[wr_addr]       <= wr_color;
         pixel_alpha_depth_ff[wr_addr] <= wr_ad;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         rd_color_ff <= pixel_color_ff[addr_ff];
         rd_ad_ff    <= pixel_alpha_depth_ff[addr_ff];
      end
   end

   assign old_depth = rd_ad_ff[DEPTH_W-1:0];

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_red_in   = rsp_red_ff;
      rsp_green_in = rsp_green_ff;
      rsp_blue_in  = rsp_blue_ff;
      rsp_alpha_in = rsp_alpha_ff;
      rsp_depth_in = rsp_depth_ff;
      rsp_hit_in   = rsp_hit_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = hit_ff;
         if (hit_ff) begin
            rsp_red_in   = rd_color_ff[COLOR_W-1:0];
            rsp_green_in = rd_color_ff[2*COLOR_W-1:COLOR_W];
            rsp_blue_in  = rd_color_ff[COLOR3_W-1:2*COLOR_W];
            rsp_alpha_in = rd_ad_ff[AD_W-1:DEPTH_W];
            rsp_depth_in = old_depth;
         end else begin
            rsp_red_in   = '0;
            rsp_green_in = '0;
            rsp_blue_in  = '0;
            rsp_alpha_in = '0;
            rsp_depth_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_red_ff   <= rsp_red_in;
      rsp_green_ff <= rsp_green_in;
      rsp_blue_ff  <= rsp_blue_in;
      rsp_alpha_ff <= rsp_alpha_in;
      rsp_depth_ff <= rsp_depth_in;
      rsp_hit_ff   <= rsp_hit_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_depth_ff, rsp_alpha_ff, rsp_blue_ff, rsp_green_ff,
                        rsp_red_ff};
   assign rsp_tuser  = rsp_hit_ff;

   always_comb begin
      status.kind       = kind_ff;
      status.hit        = hit_ff;
      status.depth_pass = (old_depth == '0) || ($signed(depth_ff) < $signed(old_depth));
      status.clear_more = (cursor_ff < total_ff);
      status.rsp_free   = !rsp_valid_ff || rsp_tready;
   end

   a_cursor_rest: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_done |=> (cursor_ff == '0))
      else $error("clear cursor not returned to zero after clear");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_tvalid)
      else $error("loaded result not presented");

   a_write_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.pix_wr |-> hit_ff)
      else $error("pixel write issued for out-of-range coordinates");

endmodule

// File: rtl/zbuffer_frame_store.sv
// Top level of the z-buffered frame store.
//
// Request channel req_*: tuser carries the request kind (clear, write, read or
// ignore), tdata the coordinates, colors, alpha and depth. Result channel rsp_*: one
// item per read, tdata holding the stored pixel, tuser the in-range flag.
// The csr_* port sets frame width and height; write it only while idle.
//
// A write or read item steps through capture, address multiply, registered
// memory read, and depth test or result load. A read result is registered in
// the output register and shown on rsp_tvalid.
// A clear writes one pixel per cycle over the capped width * height pixels.
//
// Reset returns the controller to idle, empties the output register and sets
// width and height to 256; pixel contents are undefined until cleared.
// While a result waits on rsp_tready the next item is still accepted; a
// following read then holds in its last step until the output register frees.
module zbuffer_frame_store import zbfs_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // pos_x[11:0], pos_y[23:12], red_in[39:24], green_in[55:40],
   // blue_in[71:56], alpha_in[87:72], depth_in[119:88]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // red_out[11:0], green_out[23:12], blue_out[35:24], alpha_out[51:36],
   // depth_out[83:52], zero fill [87:84]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // in_range[0]
   output logic                   rsp_tuser,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic [CFG_W-1:0] frame_width;
   logic [CFG_W-1:0] frame_height;
   ctrl_cmd_type     cmd;
   dp_status_type    status;

   zbfs_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .frame_width  (frame_width),
      .frame_height (frame_height)
   );

   zbfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   zbfs_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .frame_width  (frame_width),
      .frame_height (frame_height),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

endmodule

// File: tb/sv/zbuffer_frame_store_test.sv
// Self-checking testbench of the z-buffered frame store: directed table, then random traffic.
`timescale 1ns / 1ps

module zbuffer_frame_store_test;
   import zbfs_pkg::*;

   localparam int FRAME_MAX_W = 256;
   localparam int FRAME_MAX_H = 256;
   localparam int PIXEL_SLOTS = FRAME_MAX_W * FRAME_MAX_H;
   localparam int STALL_LIMIT = 200000;
   localparam int PHASE_COUNT = 9;
   localparam int PHASE_ITEMS = 60;
   localparam int HOLD_AFTER  = 300;
   localparam int HOLD_CYCLES = 600;

   localparam logic [CSR_ADDR_W-1:0] ADDR_FRAME_WIDTH  = {REG_FRAME_WIDTH, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_FRAME_HEIGHT = {REG_FRAME_HEIGHT, 2'b00};

   typedef struct packed {
      req_kind_type       kind;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
      logic [ALPHA_W-1:0] alpha;
      logic [DEPTH_W-1:0] depth;
   } frame_req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic [ALPHA_W-1:0] alpha;
      logic [DEPTH_W-1:0] depth;
      logic               hit;
   } pixel_rsp_type;

   typedef struct packed {
      frame_req_type rq;
      logic          typed;
      pixel_rsp_type want;
   } dir_row_type;

   localparam pixel_rsp_type PIX_NONE  = '0;
   localparam pixel_rsp_type PIX_WHITE = '{COLOR_WHITE, COLOR_WHITE, COLOR_WHITE,
                                           CLEAR_ALPHA, CLEAR_DEPTH, 1'b1};

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   // pos_x, pos_y, red_in, green_in, blue_in, alpha_in, depth_in
   logic [REQ_TDATA_W-1:0] req_tdata;
   // req_type
   logic [REQ_TUSER_W-1:0] req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // red_out, green_out, blue_out, alpha_out, depth_out, zero fill
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // in_range
   logic                   rsp_tuser;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   logic [COLOR_W-1:0] px_red   [PIXEL_SLOTS];
   logic [COLOR_W-1:0] px_green [PIXEL_SLOTS];
   logic [COLOR_W-1:0] px_blue  [PIXEL_SLOTS];
   logic [ALPHA_W-1:0] px_alpha [PIXEL_SLOTS];
   logic [DEPTH_W-1:0] px_depth [PIXEL_SLOTS];
   logic [CFG_W-1:0]   frame_width_reg;
   logic [CFG_W-1:0]   frame_height_reg;

   pixel_rsp_type read_results_due [$];
   int errors      = 0;
   int items_sent  = 0;
   int burst_left  = 0;
   int idle_cycles = 0;

   int phase_w [PHASE_COUNT] = '{0, 7, 1, 511, 3, 16, 5, 256, 2};
   int phase_h [PHASE_COUNT] = '{5, 0, 1, 3, 511, 12, 9, 2, 256};

   dir_row_type directed_rows [23] = '{
      '{'{REQ_READ,   12'hfff, 12'h000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0},
        1'b1, PIX_NONE},
      '{'{REQ_READ,   12'h7ff, 12'h7ff, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0},
        1'b1, PIX_NONE},
      '{'{REQ_IGNORE, 12'hfff, 12'hfff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 32'hffffffff},
        1'b0, PIX_NONE},
      '{'{REQ_CLEAR,  12'h000, 12'h000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0},
        1'b0, PIX_NONE},
      '{'{REQ_READ,   12'h000, 12'h000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0},
        1'b1, PIX_WHITE},
      '{'{REQ_READ,   12'h0ff, 12'h0ff, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0},
        1'b1, PIX_WHITE},
      '{'{REQ_READ,   12'h100, 12'h000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0},
        1'b1, PIX_NONE},
      '{'{REQ_READ,   12'h000, 12'h100, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0},
        1'b1, PIX_NONE},
      '{'{REQ_WRITE,  12'h000, 12'h000, 16'h8000, 16'h7fff, 16'h0fff, 16'h8000, 32'h80000000},
        1'b0, PIX_NONE},
      '{'{REQ_READ,   12'h000, 12'h000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0},
        1'b0, PIX_NONE},
      '{'{REQ_WRITE,  12'h000, 12'h000, 16'h0100, 16'h0100, 16'h0100, 16'h0005, 32'h5},
        1'b0, PIX_NONE},
      '{'{REQ_READ,   12'h000, 12'h000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0},
        1'b0, PIX_NONE},
      '{'{REQ_WRITE,  12'h0ff, 12'h0ff, 16'h1000, 16'hffff, 16'h0000, 16'h7fff, 32'h7fffffff},
        1'b0, PIX_NONE},
      '{'{REQ_WRITE,  12'h0ff, 12'h0ff, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 32'h7fffffff},
        1'b0, PIX_NONE},
      '{'{REQ_WRITE,  12'h0ff, 12'h0ff, 16'h0fff, 16'h0ffe, 16'h0001, 16'hffff, 32'h0},
        1'b0, PIX_NONE},
      '{'{REQ_WRITE,  12'h0ff, 12'h0ff, 16'h0007, 16'h0008, 16'h0009, 16'h0002, 32'h64},
        1'b0, PIX_NONE},
      '{'{REQ_READ,   12'h0ff, 12'h0ff, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0},
        1'b0, PIX_NONE},
      '{'{REQ_WRITE,  12'h800, 12'h005, 16'h0123, 16'h0456, 16'h0789, 16'h0001, 32'h1},
        1'b0, PIX_NONE},
      '{'{REQ_WRITE,  12'h000, 12'h800, 16'h0123, 16'h0456, 16'h0789, 16'h0001, 32'h1},
        1'b0, PIX_NONE},
      '{'{REQ_IGNORE, 12'h003, 12'h003, 16'h0111, 16'h0222, 16'h0333, 16'h0444, 32'h1},
        1'b0, PIX_NONE},
      '{'{REQ_READ,   12'h080, 12'h040, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0},
        1'b1, PIX_WHITE},
      '{'{REQ_READ,   12'h800, 12'h800, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0},
        1'b1, PIX_NONE},
      '{'{REQ_READ,   12'h000, 12'h000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0},
        1'b0, PIX_NONE}
   };

   zbuffer_frame_store #(
      .MAX_WIDTH  (FRAME_MAX_W),
      .MAX_HEIGHT (FRAME_MAX_H)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int eff_size(input logic [CFG_W-1:0] v, input int limit);
      return (int'(v) > limit) ? limit : int'(v);
   endfunction

   function automatic logic [COLOR_W-1:0] clamp_color(input logic [CHAN_W-1:0] v);
      if ($signed(v) < 0) return '0;
      if ($signed(v) > 4095) return COLOR_MAX;
      return v[COLOR_W-1:0];
   endfunction

   function automatic void apply_to_frame(input frame_req_type rq, output logic gives,
                                          output pixel_rsp_type res);
      int   w, h, x, y, addr, total;
      logic in_frame;
      gives = 1'b0;
      res   = '0;
      w = eff_size(frame_width_reg, FRAME_MAX_W);
      h = eff_size(frame_height_reg, FRAME_MAX_H);
      x = int'($signed(rq.x));
      y = int'($signed(rq.y));
      in_frame = (x >= 0) && (y >= 0) && (x < w) && (y < h);
      addr = in_frame ? (y * w + x) % PIXEL_SLOTS : 0;
      case (rq.kind)
         REQ_CLEAR: begin
            total = w * h;
            for (int i = 0; i < total && i < PIXEL_SLOTS; i++) begin
               px_red[i]   = COLOR_WHITE;
               px_green[i] = COLOR_WHITE;
               px_blue[i]  = COLOR_WHITE;
               px_alpha[i] = CLEAR_ALPHA;
               px_depth[i] = CLEAR_DEPTH;
            end
         end
         REQ_WRITE: begin
            if (in_frame && (px_depth[addr] == 0 ||
                             $signed(rq.depth) < $signed(px_depth[addr]))) begin
               px_red[addr]   = clamp_color(rq.red);
               px_green[addr] = clamp_color(rq.green);
               px_blue[addr]  = clamp_color(rq.blue);
               px_alpha[addr] = rq.alpha;
               px_depth[addr] = rq.depth;
            end
         end
         REQ_READ: begin
            gives = 1'b1;
            if (in_frame)
               res = '{px_red[addr], px_green[addr], px_blue[addr],
                       px_alpha[addr], px_depth[addr], 1'b1};
         end
         default: ;
      endcase
   endfunction

   function automatic logic [CHAN_W-1:0] random_chan();
      case ($urandom_range(0, 3))
         0: return CHAN_W'($urandom);
         1: begin
            case ($urandom_range(0, 3))
               0: return 16'h0000;
               1: return 16'h0fff;
               2: return 16'h1000;
               default: return 16'hffff;
            endcase
         end
         default: return CHAN_W'($urandom_range(0, 4095));
      endcase
   endfunction

   function automatic logic [DEPTH_W-1:0] random_depth();
      case ($urandom_range(0, 4))
         0: return DEPTH_W'($urandom);
         1: return DEPTH_W'($urandom_range(0, 20) - 10);
         2: return '0;
         default: return DEPTH_W'($urandom_range(1, 40));
      endcase
   endfunction

   function automatic frame_req_type random_request();
      frame_req_type rq;
      int w, h, x, y, sel;
      w = eff_size(frame_width_reg, FRAME_MAX_W);
      h = eff_size(frame_height_reg, FRAME_MAX_H);
      sel = $urandom_range(0, 99);
      if (sel < 3 && w * h <= 1024) rq.kind = REQ_CLEAR;
      else if (sel < 6) rq.kind = REQ_IGNORE;
      else if (sel < 52) rq.kind = REQ_WRITE;
      else rq.kind = REQ_READ;
      if ($urandom_range(0, 99) < 80 && w > 0 && h > 0) begin
         if ($urandom_range(0, 1) == 1) begin
            x = $urandom_range(0, ((w < 4) ? w : 4) - 1);
            y = $urandom_range(0, ((h < 4) ? h : 4) - 1);
         end else begin
            x = $urandom_range(0, w - 1);
            y = $urandom_range(0, h - 1);
         end
      end else begin
         case ($urandom_range(0, 3))
            0: begin
               x = $urandom;
               y = $urandom;
            end
            1: begin
               x = w;
               y = (h > 0) ? $urandom_range(0, h - 1) : 0;
            end
            2: begin
               x = (w > 0) ? $urandom_range(0, w - 1) : 0;
               y = h;
            end
            default: begin
               x = -int'($urandom_range(1, 2048));
               y = $urandom_range(0, 2047);
            end
         endcase
      end
      rq.x     = x[COORD_W-1:0];
      rq.y     = y[COORD_W-1:0];
      rq.red   = random_chan();
      rq.green = random_chan();
      rq.blue  = random_chan();
      rq.alpha = ALPHA_W'($urandom);
      rq.depth = random_depth();
      return rq;
   endfunction

   task automatic check_field(input string name, input logic [DEPTH_W-1:0] want,
                              input logic [DEPTH_W-1:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s expected %h got %h", $time, name, want, got);
      end
   endtask

   task automatic offer(input frame_req_type rq, input logic typed, input pixel_rsp_type want);
      int            gap;
      logic          gives;
      pixel_rsp_type got;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 8);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 10);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= rq.kind;
      req_tdata  <= {rq.depth, rq.alpha, rq.blue, rq.green, rq.red, rq.y, rq.x};
      do @(posedge clock); while (!req_tready);
      apply_to_frame(rq, gives, got);
      if (gives) read_results_due.push_back(typed ? want : got);
      items_sent++;
   endtask

   task automatic run_random(input int count);
      frame_req_type rq;
      for (int i = 0; i < count; i++)
         offer(random_request(), 1'b0, PIX_NONE);
      // end on a read so its result proves every earlier item done
      rq      = random_request();
      rq.kind = REQ_READ;
      rq.x    = '0;
      rq.y    = '0;
      offer(rq, 1'b0, PIX_NONE);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (read_results_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_frame_regs();
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b0, ADDR_FRAME_WIDTH, '0, rd);
      check_field("frame_width", DEPTH_W'(frame_width_reg), DEPTH_W'(rd[CFG_W-1:0]));
      csr_access(1'b0, ADDR_FRAME_HEIGHT, '0, rd);
      check_field("frame_height", DEPTH_W'(frame_height_reg), DEPTH_W'(rd[CFG_W-1:0]));
   endtask

   task automatic set_frame(input int w, input int h);
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b1, ADDR_FRAME_WIDTH, CSR_DATA_W'(w), rd);
      csr_access(1'b1, ADDR_FRAME_HEIGHT, CSR_DATA_W'(h), rd);
      frame_width_reg  = w[CFG_W-1:0];
      frame_height_reg = h[CFG_W-1:0];
      check_frame_regs();
   endtask

   initial begin
      frame_req_type rq;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      frame_width_reg  = FRAME_RESET;
      frame_height_reg = FRAME_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_frame_regs();
      foreach (directed_rows[i])
         offer(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);
      run_random(PHASE_ITEMS);
      drain();
      for (int p = 0; p < PHASE_COUNT; p++) begin
         set_frame(phase_w[p], phase_h[p]);
         rq      = random_request();
         rq.kind = REQ_CLEAR;
         offer(rq, 1'b0, PIX_NONE);
         run_random(PHASE_ITEMS);
         drain();
      end
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      int            mode, mode_left, hold_left;
      logic          held;
      pixel_rsp_type want, got;
      rsp_tready = 1'b0;
      mode       = 0;
      mode_left  = 0;
      hold_left  = 0;
      held       = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[11:0], rsp_tdata[23:12], rsp_tdata[35:24],
                    rsp_tdata[51:36], rsp_tdata[83:52], rsp_tuser};
            if (read_results_due.size() == 0) begin
               errors++;
               $display("%0t: result item with none expected, got %h", $time, got);
            end else begin
               want = read_results_due.pop_front();
               check_field("red_out", DEPTH_W'(want.red), DEPTH_W'(got.red));
               check_field("green_out", DEPTH_W'(want.green), DEPTH_W'(got.green));
               check_field("blue_out", DEPTH_W'(want.blue), DEPTH_W'(got.blue));
               check_field("alpha_out", DEPTH_W'(want.alpha), DEPTH_W'(got.alpha));
               check_field("depth_out", want.depth, got.depth);
               check_field("in_range", DEPTH_W'(want.hit), DEPTH_W'(got.hit));
            end
         end
         // hold off once for a long stretch so the block backs up
         if (!held && items_sent >= HOLD_AFTER) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 100);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 1) == 1);
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable && csr_pready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("simulation failed");
      $finish;
   end

endmodule
